// ===== sv/plm_pkg.sv =====
// shared codes and types for the posting list merge unit
package plm_pkg;

  // input word kinds
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_STEP = 1'b1;

  // merge modes
  localparam logic MODE_AND = 1'b0;
  localparam logic MODE_OR  = 1'b1;

  // configuration register indexes
  localparam logic CFG_OP_MODE    = 1'b0;
  localparam logic CFG_LIST_COUNT = 1'b1;

  // result kinds
  localparam logic [1:0] RK_MATCH = 2'd0;
  localparam logic [1:0] RK_NEXT  = 2'd1;
  localparam logic [1:0] RK_JUMP  = 2'd2;
  localparam logic [1:0] RK_DONE  = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_REQ
  } plm_state_t;

endpackage

// ===== sv/plm_head_store.sv =====
// head id memory with registered read plus per-list exhausted flags
module plm_head_store import plm_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int IDW   = 32,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  logic [AW-1:0]  wr_addr,
  input  logic [IDW-1:0] wr_id,
  input  logic           wr_exh,
  input  logic           rd_en,
  input  logic [AW-1:0]  rd_addr,
  output logic [IDW-1:0] rd_id,
  output logic           rd_exh
);

  logic [IDW-1:0]   mem [DEPTH];
  logic [DEPTH-1:0] exh_r;
  logic [IDW-1:0]   rd_id_r;
  logic             rd_exh_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_id;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_id_r <= mem[rd_addr];
    end
  end

  // exhausted flags come up set, so an unloaded list never reads its id
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exh_r <= '1;
    end else if (wr_en) begin
      exh_r[wr_addr] <= wr_exh;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_exh_r <= exh_r[rd_addr];
    end
  end

  assign rd_id  = rd_id_r;
  assign rd_exh = rd_exh_r;

endmodule

// ===== sv/posting_list_merge_unit.sv =====
// Posting list merge unit: k-way union/intersection step over stored list heads.
// Load word: writes one head, gives no result.
// Step word: n = min(list_count, MAX_LISTS); scan n heads for min/max, one decide state, then
// up to n request steps, one head per cycle through the single read port of the head memory
// (the walk holds while a hit waits for the output slot). Results leave one per cycle through
// an output register while out_stall is low. Reset: op_mode AND, list_count 0, every list exhausted.
module posting_list_merge_unit import plm_pkg::*; #(
  parameter int MAX_LISTS = 16,
  parameter int ID_BITS   = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // input words
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [3:0]  in_list_index,
  input  logic [31:0] in_head_id,
  input  logic        in_exhausted,
  // result words
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_result_kind,
  output logic [3:0]  out_target_list,
  output logic [31:0] out_id,
  output logic        out_last,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [4:0]  cfg_data
);

  localparam int AW = $clog2(MAX_LISTS);
  localparam int CW = $clog2(MAX_LISTS + 1);

  plm_state_t state_r, state_nxt;

  logic               op_mode_r;
  logic [4:0]         list_count_r;
  logic [CW-1:0]      n_eff;

  logic [AW-1:0]      cur_r, cur_nxt;
  logic [AW-1:0]      lastmin_r, lastmin_nxt;
  logic [ID_BITS-1:0] mn_r, mn_nxt, mx_r, mx_nxt;
  logic               live_r, live_nxt, dead_r, dead_nxt;

  logic               out_valid_r;
  logic [1:0]         out_kind_r, out_kind_nxt;
  logic [3:0]         out_list_r, out_list_nxt;
  logic [31:0]        out_id_r, out_id_nxt;
  logic               out_last_r, out_last_nxt;
  logic               out_load;
  logic               slot_free;

  logic               in_acc;
  logic               load_ok;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic [ID_BITS-1:0] rd_id;
  logic               rd_exh;

  logic               more;
  logic               done_c;
  logic               match_c;
  logic               hit;
  logic               is_last;

  // ---------------------------------------------------------------------------
  // head store

  assign load_ok = in_acc && (in_kind == KIND_LOAD) && (32'(in_list_index) < MAX_LISTS);

  plm_head_store #(
    .DEPTH (MAX_LISTS),
    .IDW   (ID_BITS)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (load_ok),
    .wr_addr (AW'(in_list_index)),
    .wr_id   (ID_BITS'(in_head_id)),
    .wr_exh  (in_exhausted),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_id   (rd_id),
    .rd_exh  (rd_exh)
  );

  // ---------------------------------------------------------------------------
  // configuration

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_mode_r    <= MODE_AND;
      list_count_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_OP_MODE:    op_mode_r    <= cfg_data[0];
        CFG_LIST_COUNT: list_count_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign n_eff = (32'(list_count_r) > MAX_LISTS) ? CW'(MAX_LISTS) : CW'(list_count_r);

  // ---------------------------------------------------------------------------
  // control decode

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;
  assign more      = (32'(cur_r) + 32'd1) < 32'(n_eff);
  assign done_c    = !live_r || ((op_mode_r == MODE_AND) && dead_r);
  assign match_c   = (op_mode_r == MODE_OR) || (mn_r == mx_r);
  assign hit       = (op_mode_r == MODE_OR) ? (!rd_exh && (rd_id == mn_r)) : (rd_id == mn_r);
  assign is_last   = (cur_r == lastmin_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_kind == KIND_STEP)) begin
          state_nxt = (n_eff == '0) ? ST_DECIDE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!more) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (done_c) begin
          if (slot_free) state_nxt = ST_IDLE;
        end else if (!match_c || slot_free) begin
          state_nxt = ST_REQ;
        end
      end
      ST_REQ: begin
        if (hit && is_last && slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // datapath and result loading

  always_comb begin
    rd_en        = 1'b0;
    rd_addr      = '0;
    cur_nxt      = cur_r;
    lastmin_nxt  = lastmin_r;
    mn_nxt       = mn_r;
    mx_nxt       = mx_r;
    live_nxt     = live_r;
    dead_nxt     = dead_r;
    out_load     = 1'b0;
    out_kind_nxt = RK_MATCH;
    out_list_nxt = '0;
    out_id_nxt   = '0;
    out_last_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_kind == KIND_STEP)) begin
          live_nxt = 1'b0;
          dead_nxt = 1'b0;
          cur_nxt  = '0;
          rd_en    = 1'b1;
        end
      end
      ST_SCAN: begin
        if (rd_exh) begin
          dead_nxt = 1'b1;
        end else begin
          if (!live_r || (rd_id < mn_r)) begin
            mn_nxt      = rd_id;
            lastmin_nxt = cur_r;
          end else if (rd_id == mn_r) begin
            lastmin_nxt = cur_r;
          end
          if (!live_r || (rd_id > mx_r)) begin
            mx_nxt = rd_id;
          end
          live_nxt = 1'b1;
        end
        if (more) begin
          cur_nxt = cur_r + 1'b1;
          rd_en   = 1'b1;
          rd_addr = cur_r + 1'b1;
        end
      end
      ST_DECIDE: begin
        if (done_c) begin
          if (slot_free) begin
            out_load     = 1'b1;
            out_kind_nxt = RK_DONE;
            out_last_nxt = 1'b1;
          end
        end else if (!match_c || slot_free) begin
          out_load   = match_c;
          out_id_nxt = 32'(mn_r);
          cur_nxt    = '0;
          rd_en      = 1'b1;
        end
      end
      ST_REQ: begin
        // hold the read data while a hit waits for the output slot
        if (!hit || slot_free) begin
          if (hit) begin
            out_load     = 1'b1;
            out_list_nxt = 4'(cur_r);
            out_last_nxt = is_last;
            if ((op_mode_r == MODE_OR) || (rd_id == mx_r)) begin
              out_kind_nxt = RK_NEXT;
            end else begin
              out_kind_nxt = RK_JUMP;
              out_id_nxt   = 32'(mx_r);
            end
          end
          if (!(hit && is_last) && more) begin
            cur_nxt = cur_r + 1'b1;
            rd_en   = 1'b1;
            rd_addr = cur_r + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r     <= cur_nxt;
    lastmin_r <= lastmin_nxt;
    mn_r      <= mn_nxt;
    mx_r      <= mx_nxt;
    live_r    <= live_nxt;
    dead_r    <= dead_nxt;
    if (out_load) begin
      out_kind_r <= out_kind_nxt;
      out_list_r <= out_list_nxt;
      out_id_r   <= out_id_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_kind = out_kind_r;
  assign out_target_list = out_list_r;
  assign out_id          = out_id_r;
  assign out_last        = out_last_r;

  // ---------------------------------------------------------------------------
  // checks

  // the request walk never passes the last list found at the minimum
  a_req_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_REQ) |-> (cur_r <= lastmin_r))
    else $error("request walk passed last minimum list");

  // done always closes the step by itself
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_result_kind == RK_DONE)) |-> out_last)
    else $error("done result without last");

  // a step holds off further input while it works
  a_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_kind == KIND_STEP)) |=> in_stall)
    else $error("input taken during step");

  // a head load produces no result
  a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_kind == KIND_LOAD) && !out_valid) |=> !out_valid)
    else $error("result after head load");

endmodule

// ===== verif/posting_list_merge_unit_tb.sv =====
// self-checking testbench for the posting list merge unit
module posting_list_merge_unit_tb import plm_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_LISTS     = 16;
  localparam int SETTLE_CYCLES = 4 * MAX_LISTS + 8;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int TOTAL_WORDS   = 420;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  list;
    logic [31:0] id;
    logic        last;
  } merge_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_kind = KIND_LOAD;
  logic [3:0]  in_list_index = '0;
  logic [31:0] in_head_id = '0;
  logic        in_exhausted = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_result_kind;
  logic [3:0]  out_target_list;
  logic [31:0] out_id;
  logic        out_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = CFG_OP_MODE;
  logic [4:0]  cfg_data = '0;

  // predictor copy of the block state
  logic        pred_mode = MODE_AND;
  logic [4:0]  pred_lists = '0;
  logic [31:0] pred_head_id [MAX_LISTS];
  bit          pred_head_gone [MAX_LISTS];

  merge_result_t expected_results[$];
  merge_result_t last_step_results[$];

  int  errors = 0;
  int  words_sent = 0;
  int  steps_sent = 0;
  int  results_seen = 0;
  int  matches_seen = 0;
  int  dones_seen = 0;
  int  jumps_seen = 0;
  int  cfg_writes = 0;
  int  cycles_run = 0;
  int  rx_hold_left = 0;
  bit  tx_idle_on = 1'b1;
  bit  rx_idle_on = 1'b1;

  posting_list_merge_unit i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_list_index   (in_list_index),
    .in_head_id      (in_head_id),
    .in_exhausted    (in_exhausted),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_result_kind (out_result_kind),
    .out_target_list (out_target_list),
    .out_id          (out_id),
    .out_last        (out_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // results of one merge step over the current heads
  function automatic void predict_merge_step();
    int          n;
    logic [31:0] lo;
    logic [31:0] hi;
    bit          seen_live;
    bit          seen_gone;
    n = (int'(pred_lists) > MAX_LISTS) ? MAX_LISTS : int'(pred_lists);
    lo = '1;
    hi = '0;
    seen_live = 1'b0;
    seen_gone = 1'b0;
    last_step_results.delete();
    for (int i = 0; i < n; i++) begin
      if (pred_head_gone[i]) begin
        seen_gone = 1'b1;
      end else begin
        if (!seen_live || pred_head_id[i] < lo) lo = pred_head_id[i];
        if (!seen_live || pred_head_id[i] > hi) hi = pred_head_id[i];
        seen_live = 1'b1;
      end
    end
    if (n == 0 || !seen_live || (pred_mode == MODE_AND && seen_gone)) begin
      last_step_results.push_back('{RK_DONE, 4'd0, 32'd0, 1'b0});
    end else if (pred_mode == MODE_OR) begin
      last_step_results.push_back('{RK_MATCH, 4'd0, lo, 1'b0});
      for (int i = 0; i < n; i++)
        if (!pred_head_gone[i] && pred_head_id[i] == lo)
          last_step_results.push_back('{RK_NEXT, 4'(i), 32'd0, 1'b0});
    end else begin
      if (lo == hi) last_step_results.push_back('{RK_MATCH, 4'd0, lo, 1'b0});
      for (int i = 0; i < n; i++) begin
        if (pred_head_id[i] == lo) begin
          if (lo == hi) last_step_results.push_back('{RK_NEXT, 4'(i), 32'd0, 1'b0});
          else last_step_results.push_back('{RK_JUMP, 4'(i), hi, 1'b0});
        end
      end
    end
    last_step_results[last_step_results.size() - 1].last = 1'b1;
    foreach (last_step_results[j]) expected_results.push_back(last_step_results[j]);
  endfunction

  task automatic send_word(logic kind, logic [3:0] idx, logic [31:0] id, logic gone);
    while (tx_idle_on && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_kind       <= kind;
    in_list_index <= idx;
    in_head_id    <= id;
    in_exhausted  <= gone;
    do @(posedge clk); while (in_stall);
    words_sent++;
    if (kind == KIND_LOAD) begin
      pred_head_id[idx]   = id;
      pred_head_gone[idx] = gone;
    end else begin
      steps_sent++;
      predict_merge_step();
    end
  endtask

  task automatic load_head(logic [3:0] idx, logic [31:0] id, logic gone);
    send_word(KIND_LOAD, idx, id, gone);
  endtask

  // the unused fields of a step word carry random values
  task automatic merge_step();
    send_word(KIND_STEP, 4'($urandom), $urandom, 1'($urandom));
  endtask

  // sender stops and waits for every pending result, then for the block to go quiet
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(logic idx, logic [4:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_writes++;
    if (idx == CFG_OP_MODE) pred_mode = data[0];
    else pred_lists = data;
    @(posedge clk);
  endtask

  task automatic set_merge(logic mode, logic [4:0] lists);
    settle();
    write_config(CFG_OP_MODE, {4'($urandom_range(15)), mode});
    write_config(CFG_LIST_COUNT, lists);
  endtask

  // answer one request the way a list iterator would
  task automatic advance_list(merge_result_t req);
    logic [31:0] start;
    start = (req.kind == RK_JUMP) ? req.id : pred_head_id[req.list];
    if (start > 32'hFFFF_FFF0 || $urandom_range(99) < 8)
      load_head(req.list, $urandom, 1'b1);
    else if (req.kind == RK_JUMP)
      load_head(req.list, start + $urandom_range(2), 1'b0);
    else
      load_head(req.list, start + 1 + $urandom_range(2), 1'b0);
  endtask

  // a full merge with random heads, answered requests and some noise
  task automatic run_merge(logic mode, logic [4:0] lists);
    int            n;
    int            steps;
    int            step_cap;
    bit            finished;
    logic [31:0]   base;
    merge_result_t reqs[$];
    set_merge(mode, lists);
    n = (int'(lists) > MAX_LISTS) ? MAX_LISTS : int'(lists);
    step_cap = (n > 5) ? 4 : 30;
    base = $urandom_range(32'hFFFF_0000, 0);
    for (int i = 0; i < n; i++)
      load_head(4'(i), base + $urandom_range(3), $urandom_range(99) < 5);
    steps = 0;
    finished = 1'b0;
    while (!finished && steps < step_cap) begin
      if ($urandom_range(99) < 10)
        load_head(4'($urandom), $urandom, 1'($urandom));
      merge_step();
      steps++;
      reqs = last_step_results;
      finished = (reqs[0].kind == RK_DONE);
      foreach (reqs[j])
        if ((reqs[j].kind == RK_NEXT || reqs[j].kind == RK_JUMP) && $urandom_range(99) >= 4)
          advance_list(reqs[j]);
    end
  endtask

  task automatic test_reset_state();
    merge_step();
    settle();
    write_config(CFG_LIST_COUNT, 5'd16);
    merge_step();
    settle();
    write_config(CFG_OP_MODE, MODE_OR);
    merge_step();
  endtask

  task automatic test_union_directed();
    set_merge(MODE_OR, 5'd3);
    load_head(4'd0, 32'hFFFF_FFFF, 1'b0);
    load_head(4'd1, 32'h0000_0000, 1'b0);
    load_head(4'd2, 32'h0000_0000, 1'b0);
    merge_step();
    load_head(4'd1, 32'h8000_0001, 1'b1);
    merge_step();
    // a count above the list array size clamps to all lists
    set_merge(MODE_OR, 5'd31);
    merge_step();
  endtask

  task automatic test_intersect_directed();
    set_merge(MODE_AND, 5'd2);
    load_head(4'd0, 32'hFFFF_FFFF, 1'b0);
    load_head(4'd1, 32'hFFFF_FFFF, 1'b0);
    merge_step();
    load_head(4'd0, 32'h5555_5555, 1'b0);
    merge_step();
    load_head(4'd2, 32'hAAAA_AAAA, 1'b0);
    set_merge(MODE_AND, 5'd1);
    merge_step();
    set_merge(MODE_AND, 5'd17);
    merge_step();
    set_merge(MODE_AND, 5'd2);
    load_head(4'd1, 32'h1234_5678, 1'b1);
    merge_step();
  endtask

  task automatic test_random_merges(int goal);
    int r;
    logic [4:0] lists;
    while (words_sent < goal) begin
      r = $urandom_range(99);
      if (r < 6) lists = 5'd0;
      else if (r < 12) lists = 5'd1;
      else if (r < 20) lists = 5'($urandom_range(31, 17));
      else if (r < 28) lists = 5'd16;
      else lists = 5'($urandom_range(5, 2));
      run_merge(1'($urandom), lists);
    end
  endtask

  task automatic test_output_backpressure();
    logic [31:0] id;
    set_merge(MODE_OR, 5'd16);
    id = $urandom;
    for (int i = 0; i < MAX_LISTS; i++) load_head(4'(i), id, 1'b0);
    tx_idle_on = 1'b0;
    rx_hold_left = 300;
    // every step yields a match plus sixteen next requests
    repeat (6) merge_step();
    tx_idle_on = 1'b1;
    settle();
  endtask

  task automatic test_steady_stream();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    run_merge(MODE_AND, 5'd3);
    run_merge(MODE_OR, 5'd4);
    run_merge(MODE_AND, 5'd16);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // receiver side: random stalls, or a counted hold-off when requested
  always @(posedge clk) begin
    if (rx_hold_left > 0) begin
      out_stall <= 1'b1;
      rx_hold_left = rx_hold_left - 1;
    end else begin
      out_stall <= rx_idle_on && ($urandom_range(99) < 31);
    end
  end

  always @(posedge clk) begin : check_results
    merge_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (out_result_kind == RK_MATCH) matches_seen++;
      if (out_result_kind == RK_DONE) dones_seen++;
      if (out_result_kind == RK_JUMP) jumps_seen++;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected word kind %0d list %0d id %h last %0b", $time,
                 out_result_kind, out_target_list, out_id, out_last);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (out_result_kind !== want.kind) begin
          $display("%0t: result_kind expected %0d actual %0d", $time, want.kind,
                   out_result_kind);
          errors++;
        end
        if (out_target_list !== want.list) begin
          $display("%0t: target_list expected %0d actual %0d", $time, want.list,
                   out_target_list);
          errors++;
        end
        if (out_id !== want.id) begin
          $display("%0t: out_id expected %h actual %h", $time, want.id, out_id);
          errors++;
        end
        if (out_last !== want.last) begin
          $display("%0t: last expected %0b actual %0b", $time, want.last, out_last);
          errors++;
        end
      end
    end
  end

  initial begin : watchdog
    while (cycles_run < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles_run++;
    end
    $display("timeout after %0d cycles, %0d results pending", cycles_run,
             expected_results.size());
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    for (int i = 0; i < MAX_LISTS; i++) begin
      pred_head_id[i]   = '0;
      pred_head_gone[i] = 1'b1;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_union_directed();
    test_intersect_directed();
    test_output_backpressure();
    test_random_merges(TOTAL_WORDS / 2);
    test_steady_stream();
    test_random_merges(TOTAL_WORDS);
    settle();
    $display("sent %0d words (%0d merge steps) over %0d config writes in %0d cycles",
             words_sent, steps_sent, cfg_writes, cycles_run);
    $display("checked %0d results: %0d matches, %0d jumps, %0d done, %0d mismatches",
             results_seen, matches_seen, jumps_seen, dones_seen, errors);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
